@@ hdl/lfb_pkg.sv @@
// shared types, constants and the crc helper for the logger frame builder
package lfb_pkg;

	// parameter defaults
	localparam int MAX_REGISTERS_DEF = 125;
	localparam int CMD_DEPTH_DEF     = 4;
	localparam int OUT_DEPTH_DEF     = 4;

	// frame constants
	localparam logic [7:0]  START_MARK      = 8'hA5;
	localparam logic [7:0]  END_MARK        = 8'h15;
	localparam logic [7:0]  READ_HOLDING    = 8'h03;
	localparam logic [7:0]  DATA_FRAME_TYPE = 8'h02;
	localparam logic [15:0] CRC_POLY        = 16'hA001;
	localparam logic [15:0] CRC_INIT        = 16'hFFFF;

	// length field: 15 without modbus, 20 plus byte count with modbus
	localparam int         LEN_W       = 9;
	localparam logic [8:0] LEN_PLAIN   = 9'd15;
	localparam logic [8:0] LEN_PAYLOAD = 9'd20;

	// byte positions inside the header sequence
	localparam int         IDX_W    = 5;
	localparam logic [4:0] HDR_LAST = 5'd25;
	localparam logic [4:0] PAY_FIRST = 5'd26;
	localparam logic [4:0] PAY_LAST = 5'd28;

	// input operation codes
	localparam logic OP_START = 1'b0;
	localparam logic OP_DATA  = 1'b1;

	// configuration register indexes
	localparam int         REG_IDX_W           = 2;
	localparam logic [1:0] REG_SERIAL_NO       = 2'd0;
	localparam logic [1:0] REG_UNIT_ADDRESS    = 2'd1;
	localparam logic [1:0] REG_BOOT_SECONDS    = 2'd2;

	typedef enum logic {
		CMD_START,
		CMD_DATA
	} cmd_kind_t;

	// one classified command from the front to the back
	typedef struct packed {
		cmd_kind_t         kind;
		logic [15:0]       ctrl;
		logic [15:0]       seq;
		logic [LEN_W-1:0]  len;
		logic              modbus;
		logic [7:0]        count;
		logic [31:0]       uptime;
		logic [7:0]        data;
		logic              last;
	} cmd_t;

	// one byte of the output stream
	typedef struct packed {
		logic [7:0] data;
		logic       eof;
	} out_item_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_HEAD,
		BK_CRC_LO,
		BK_CRC_HI,
		BK_SUM,
		BK_EOF
	} back_state_t;

	// modbus crc-16 over one byte, reflected, bit at a time
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

@@ hdl/lfb_fifo.sv @@
// small register queue used between the front, the back and the result port
module lfb_fifo
	import lfb_pkg::*;
#(
	parameter type item_t = logic [7:0],
	parameter int  DEPTH  = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output item_t pop_item,
	output logic  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	item_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push_ok;
	logic             pop_ok;

	// handshake qualification
	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign pop_item = mem_q[rd_ptr_q];

	// storage write
	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push_ok && !pop_ok) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop_ok && !push_ok) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// fill count tracks the difference of transactions
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push_ok && !pop_ok |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("queue count did not follow a push");

endmodule

@@ hdl/lfb_front.sv @@
// front end: accepts items, tracks frame state and classifies into commands
module lfb_front
	import lfb_pkg::*;
#(
	parameter int MAX_REGISTERS = MAX_REGISTERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        operation,
	input  logic [15:0] ctrl_code,
	input  logic        with_modbus,
	input  logic [6:0]  reg_count,
	input  logic [31:0] uptime_s,
	input  logic [7:0]  data_byte,
	output logic        cmd_push,
	output cmd_t        cmd_item,
	input  logic        cmd_full
);

	localparam int         CNT_W   = $clog2(2 * MAX_REGISTERS + 1);
	localparam logic [6:0] REG_MAX = 7'(MAX_REGISTERS);

	logic [15:0]      seq_q;
	logic             open_q;
	logic [CNT_W-1:0] remaining_q;
	logic             accept;
	logic [6:0]       regs_sat;
	logic [7:0]       pay_bytes;
	logic             data_live;

	assign full   = cmd_full;
	assign accept = push && !cmd_full;

	// register count saturation and derived lengths
	assign regs_sat   = (reg_count > REG_MAX) ? REG_MAX : reg_count;
	assign pay_bytes  = {regs_sat, 1'b0};
	assign data_live  = open_q && (remaining_q != '0);

	// command build
	always_comb begin
		cmd_item        = '0;
		cmd_item.ctrl   = ctrl_code;
		cmd_item.seq    = seq_q + 16'd1;
		cmd_item.len    = with_modbus ? (LEN_PAYLOAD + {1'b0, pay_bytes}) : LEN_PLAIN;
		cmd_item.modbus = with_modbus;
		cmd_item.count  = pay_bytes;
		cmd_item.uptime = uptime_s;
		cmd_item.data   = data_byte;
		cmd_item.last   = (remaining_q == CNT_W'(1));
		cmd_item.kind   = (operation == OP_START) ? CMD_START : CMD_DATA;
		cmd_push        = accept && ((operation == OP_START) || data_live);
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= '0;
			open_q      <= 1'b0;
			remaining_q <= '0;
		end else if (accept) begin
			if (operation == OP_START) begin
				seq_q       <= seq_q + 16'd1;
				open_q      <= with_modbus && (pay_bytes != 8'd0);
				remaining_q <= with_modbus ? pay_bytes[CNT_W-1:0] : '0;
			end else if (data_live) begin
				remaining_q <= remaining_q - CNT_W'(1);
				if (remaining_q == CNT_W'(1)) begin
					open_q <= 1'b0;
				end
			end
		end
	end

	// an open frame always expects more data bytes
	a_open_remaining: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> remaining_q != '0)
		else $error("frame open with no data bytes left");

endmodule

@@ hdl/lfb_back.sv @@
// back end: sequences header, payload and trailer bytes into the result queue
module lfb_back
	import lfb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] serial_no,
	input  logic [7:0]  modbus_unit_address,
	input  logic [31:0] boot_seconds,
	input  cmd_t        cmd_item,
	input  logic        cmd_empty,
	output logic        cmd_pop,
	output logic        out_push,
	output out_item_t   out_item,
	input  logic        out_full
);

	back_state_t       state_q;
	back_state_t       state_d;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  idx_d;
	cmd_t              cur_q;
	cmd_t              cur_d;
	logic [15:0]       crc_q;
	logic [15:0]       crc_d;
	logic [7:0]        sum_q;
	logic [7:0]        sum_d;
	logic [7:0]        hdr_byte;
	logic [31:0]       since_boot;

	assign since_boot = cur_q.uptime - boot_seconds;

	// header and modbus lead bytes by position
	always_comb begin
		unique case (idx_q)
			5'd0:    hdr_byte = START_MARK;
			5'd1:    hdr_byte = cur_q.len[7:0];
			5'd2:    hdr_byte = 8'(cur_q.len[LEN_W-1:8]);
			5'd3:    hdr_byte = cur_q.ctrl[7:0];
			5'd4:    hdr_byte = cur_q.ctrl[15:8];
			5'd5:    hdr_byte = cur_q.seq[7:0];
			5'd6:    hdr_byte = cur_q.seq[15:8];
			5'd7:    hdr_byte = serial_no[7:0];
			5'd8:    hdr_byte = serial_no[15:8];
			5'd9:    hdr_byte = serial_no[23:16];
			5'd10:   hdr_byte = serial_no[31:24];
			5'd11:   hdr_byte = DATA_FRAME_TYPE;
			5'd14:   hdr_byte = cur_q.uptime[7:0];
			5'd15:   hdr_byte = cur_q.uptime[15:8];
			5'd16:   hdr_byte = cur_q.uptime[23:16];
			5'd17:   hdr_byte = cur_q.uptime[31:24];
			5'd18:   hdr_byte = since_boot[7:0];
			5'd19:   hdr_byte = since_boot[15:8];
			5'd20:   hdr_byte = since_boot[23:16];
			5'd21:   hdr_byte = since_boot[31:24];
			5'd26:   hdr_byte = modbus_unit_address;
			5'd27:   hdr_byte = READ_HOLDING;
			5'd28:   hdr_byte = cur_q.count;
			default: hdr_byte = 8'h00;
		endcase
	end

	// sequencer next state and outputs
	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		cur_d    = cur_q;
		crc_d    = crc_q;
		sum_d    = sum_q;
		cmd_pop  = 1'b0;
		out_push = 1'b0;
		out_item = '0;
		unique case (state_q)
			BK_IDLE: begin
				if (!cmd_empty && !out_full) begin
					cmd_pop = 1'b1;
					if (cmd_item.kind == CMD_START) begin
						cur_d   = cmd_item;
						idx_d   = '0;
						crc_d   = CRC_INIT;
						sum_d   = 8'h00;
						state_d = BK_HEAD;
					end else begin
						out_push      = 1'b1;
						out_item.data = cmd_item.data;
						crc_d         = crc16_byte(crc_q, cmd_item.data);
						sum_d         = sum_q + cmd_item.data;
						if (cmd_item.last) begin
							state_d = BK_CRC_LO;
						end
					end
				end
			end
			BK_HEAD: begin
				if (!out_full) begin
					out_push      = 1'b1;
					out_item.data = hdr_byte;
					idx_d         = idx_q + IDX_W'(1);
					if (idx_q != '0) begin
						sum_d = sum_q + hdr_byte;
					end
					if (idx_q >= PAY_FIRST) begin
						crc_d = crc16_byte(crc_q, hdr_byte);
					end
					if (!cur_q.modbus && idx_q == HDR_LAST) begin
						state_d = BK_SUM;
					end else if (cur_q.modbus && idx_q == PAY_LAST) begin
						state_d = (cur_q.count == 8'd0) ? BK_CRC_LO : BK_IDLE;
					end
				end
			end
			BK_CRC_LO: begin
				if (!out_full) begin
					out_push      = 1'b1;
					out_item.data = crc_q[7:0];
					sum_d         = sum_q + crc_q[7:0];
					state_d       = BK_CRC_HI;
				end
			end
			BK_CRC_HI: begin
				if (!out_full) begin
					out_push      = 1'b1;
					out_item.data = crc_q[15:8];
					sum_d         = sum_q + crc_q[15:8];
					state_d       = BK_SUM;
				end
			end
			BK_SUM: begin
				if (!out_full) begin
					out_push      = 1'b1;
					out_item.data = sum_q;
					state_d       = BK_EOF;
				end
			end
			BK_EOF: begin
				if (!out_full) begin
					out_push      = 1'b1;
					out_item.data = END_MARK;
					out_item.eof  = 1'b1;
					state_d       = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// sequencer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			idx_q   <= '0;
			crc_q   <= CRC_INIT;
			sum_q   <= 8'h00;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			crc_q   <= crc_d;
			sum_q   <= sum_d;
		end
	end

	// current command payload
	always_ff @(posedge clk) begin
		cur_q <= cur_d;
	end

	// closing byte always follows the checksum byte
	a_eof_after_sum: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_SUM && out_push |=> state_q == BK_EOF)
		else $error("end mark did not follow the checksum");

	// end flag marks only the end byte
	a_eof_mark: assert property (@(posedge clk) disable iff (!arst_n)
		out_push && out_item.eof |-> out_item.data == END_MARK && state_q == BK_EOF)
		else $error("end flag on a byte other than the end mark");

endmodule

@@ hdl/logger_frame_builder_modbus_crc_unit.sv @@
// a data byte passes through the command queue and the back sequencer into the result queue
// a start item makes the back emit its header, one byte per cycle while the result queue has room
// throughput: one data byte per cycle while the result queue has room; a frame start holds the back
// sequencer for its header and a closing data byte for its trailer, set by its single byte lane
// reset: arst_n clears queues, frame state and sequence; config returns to serial 0, address 1, boot 0
module logger_frame_builder_modbus_crc_unit
	import lfb_pkg::*;
#(
	parameter int MAX_REGISTERS = MAX_REGISTERS_DEF,
	parameter int CMD_DEPTH     = CMD_DEPTH_DEF,
	parameter int OUT_DEPTH     = OUT_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic                 operation,
	input  logic [15:0]          ctrl_code,
	input  logic                 with_modbus,
	input  logic [6:0]           reg_count,
	input  logic [31:0]          uptime_s,
	input  logic [7:0]           data_byte,
	output logic                 empty,
	input  logic                 pop,
	output logic [7:0]           out_byte,
	output logic                 end_of_frame,
	input  logic                 write_en,
	input  logic [REG_IDX_W-1:0] write_index,
	input  logic [31:0]          write_data
);

	logic [31:0] serial_q;
	logic [7:0]  unit_address_q;
	logic [31:0] boot_seconds_q;
	logic        cmd_push;
	cmd_t        cmd_in;
	logic        cmd_full;
	cmd_t        cmd_head;
	logic        cmd_empty;
	logic        cmd_pop;
	logic        out_push;
	out_item_t   out_in;
	logic        out_full;
	out_item_t   out_head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			serial_q        <= '0;
			unit_address_q  <= 8'd1;
			boot_seconds_q  <= '0;
		end else if (write_en) begin
			unique case (write_index)
				REG_SERIAL_NO:     serial_q        <= write_data;
				REG_UNIT_ADDRESS:  unit_address_q  <= write_data[7:0];
				REG_BOOT_SECONDS:  boot_seconds_q  <= write_data;
				default:           ;
			endcase
		end
	end

	// front: accept and classify
	lfb_front #(
		.MAX_REGISTERS(MAX_REGISTERS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.operation      (operation),
		.ctrl_code      (ctrl_code),
		.with_modbus    (with_modbus),
		.reg_count      (reg_count),
		.uptime_s       (uptime_s),
		.data_byte      (data_byte),
		.cmd_push       (cmd_push),
		.cmd_item       (cmd_in),
		.cmd_full       (cmd_full)
	);

	// command queue between front and back
	lfb_fifo #(
		.item_t (cmd_t),
		.DEPTH  (CMD_DEPTH)
	) u_cmd_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_item (cmd_in),
		.full      (cmd_full),
		.pop       (cmd_pop),
		.pop_item  (cmd_head),
		.empty     (cmd_empty)
	);

	// back: byte sequencer
	lfb_back u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.serial_no           (serial_q),
		.modbus_unit_address (unit_address_q),
		.boot_seconds        (boot_seconds_q),
		.cmd_item            (cmd_head),
		.cmd_empty           (cmd_empty),
		.cmd_pop             (cmd_pop),
		.out_push            (out_push),
		.out_item            (out_in),
		.out_full            (out_full)
	);

	// result queue
	lfb_fifo #(
		.item_t (out_item_t),
		.DEPTH  (OUT_DEPTH)
	) u_out_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (out_push),
		.push_item (out_in),
		.full      (out_full),
		.pop       (pop),
		.pop_item  (out_head),
		.empty     (empty)
	);

	assign out_byte     = out_head.data;
	assign end_of_frame = out_head.eof;

endmodule
